// ===== rtl/dhf_pkg.sv =====
// dhf_pkg: shared types, constants and sizes for the hex float text formatter
// no dependencies; every other file in rtl imports it
package dhf_pkg;

  // longest text the block emits, in characters
  localparam int unsigned MAX_FIELD = 48;
  // width of the internal length arithmetic (holds MAX_FIELD plus the tail)
  localparam int unsigned LEN_W = 8;

  // descriptor queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = 1;

  // ascii codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_POINT = 8'h2e;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_X  = 8'h78;
  localparam logic [7:0] CH_LC_P  = 8'h70;
  localparam logic [7:0] CH_LC_I  = 8'h69;
  localparam logic [7:0] CH_LC_N  = 8'h6e;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  // clearing this bit turns a lowercase letter into uppercase
  localparam logic [7:0] CASE_MASK = 8'hdf;

  // sign mode codes
  localparam logic [1:0] SMODE_NONE  = 2'd0;
  localparam logic [1:0] SMODE_PLUS  = 2'd1;
  localparam logic [1:0] SMODE_SPACE = 2'd2;

  typedef struct packed {
    logic [63:0] value_bits;
    logic        uppercase;
    logic [1:0]  sign_style;
    logic        alternate;
    logic [5:0]  precision;
  } dhf_in_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
    logic       error;
  } dhf_out_t;

  // classified item handed from front to back
  typedef struct packed {
    logic        err;       // emit the single error result
    logic        special;   // inf or nan
    logic        nan;
    logic        upper;
    logic        sign_en;
    logic [7:0]  sign_ch;
    logic        lead_one;
    logic        point;
    logic [5:0]  prec;
    logic [51:0] frac;
    logic        exp_neg;
    logic [2:0]  ndig;      // decimal exponent digits, 1 to 4
    logic [15:0] exp_dig;   // bcd digits, most significant in the top nibble
  } dhf_desc_t;

endpackage

// ===== rtl/double_to_hex_float_text.sv =====
// double_to_hex_float_text: top level of the %a / %A text formatter
// depends on dhf_pkg, dhf_front, dhf_queue, dhf_back
//
// Turns the raw bits of an IEEE double plus format flags into hex float
// text, one ASCII character per output item, last set on the final one;
// a precision above MAX_FIELD (48 by default) or a text longer than
// MAX_FIELD characters gives a single item with error set instead. Fraction
// digits are truncated, never rounded.
// Both sides are queues: push/full in, empty/pop out. An item produces
// 3 to 48 characters, or one item for an error, and the sequencer takes
// a separate idle step to pick up the next descriptor; the character
// sequencer emits one character a cycle while the output register has room.
// Up to two classified items wait between the front and the sequencer, and
// the output register lets the sequencer run ahead by one character.
module double_to_hex_float_text #(
  parameter int unsigned MAX_FIELD = dhf_pkg::MAX_FIELD
) (
  input  logic              clk,
  input  logic              rst_n,
  // input item queue
  input  logic              push,
  output logic              full,
  input  dhf_pkg::dhf_in_t  in_item,
  // result queue
  output logic              empty,
  input  logic              pop,
  output dhf_pkg::dhf_out_t out_item
);
  import dhf_pkg::*;

  dhf_desc_t front_desc;   // classified item from the front part
  dhf_desc_t q_desc;       // oldest waiting descriptor
  logic      q_full;
  logic      q_empty;
  logic      q_pop;
  logic      out_valid;

  // front: sign, exponent in decimal, length check, all in the push cycle
  dhf_front #(
    .MAX_FIELD (MAX_FIELD)
  ) u_front (
    .item (in_item),
    .desc (front_desc)
  );

  // descriptor queue decouples classification from character output
  dhf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (front_desc),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_desc),
    .empty (q_empty)
  );

  // back: walks the text one character per cycle when the output is free
  dhf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_desc),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_item),
    .out_pop   (pop && out_valid)
  );

  assign full  = q_full;
  assign empty = !out_valid;

endmodule

// ===== rtl/dhf_front.sv =====
// dhf_front: takes one item apart and classifies it into a descriptor
// depends on dhf_pkg
module dhf_front #(
  parameter int unsigned MAX_FIELD = dhf_pkg::MAX_FIELD
) (
  input  dhf_pkg::dhf_in_t   item,
  output dhf_pkg::dhf_desc_t desc
);
  import dhf_pkg::*;

  logic             neg;
  logic [10:0]      bexp;
  logic [51:0]      frac;
  logic             special;
  logic             frac_nz;
  logic [9:0]       mag;
  logic             exp_neg;
  logic [3:0]       hund;
  logic [9:0]       hund_sub;
  logic [6:0]       rem1;
  logic [3:0]       tens;
  logic [6:0]       tens_sub;
  logic [3:0]       ones;
  logic [3:0]       d3;
  logic [3:0]       d2;
  logic [2:0]       ndig;
  logic [15:0]      exp_dig;
  logic             sign_en;
  logic [7:0]       sign_ch;
  logic             point;
  logic [LEN_W-1:0] body_len;
  logic [LEN_W-1:0] total_len;
  logic             err;

  assign neg     = item.value_bits[63];
  assign bexp    = item.value_bits[62:52];
  assign frac    = item.value_bits[51:0];
  assign special = (bexp == 11'h7ff);
  assign frac_nz = (frac != 52'd0);

  // unbiased exponent as sign and magnitude
  always_comb begin
    if (bexp == 11'd0) begin
      mag     = frac_nz ? 10'd1022 : 10'd0;
      exp_neg = frac_nz;
    end else if (bexp >= 11'd1023) begin
      mag     = 10'(bexp - 11'd1023);
      exp_neg = 1'b0;
    end else begin
      mag     = 10'(11'd1023 - bexp);
      exp_neg = 1'b1;
    end
  end

  // decimal digits by parallel threshold compares
  always_comb begin
    hund     = 4'd0;
    hund_sub = 10'd0;
    for (int k = 1; k <= 10; k++) begin
      if (mag >= 10'(k * 100)) begin
        hund     = 4'(k);
        hund_sub = 10'(k * 100);
      end
    end
  end

  assign rem1 = 7'(mag - hund_sub);

  always_comb begin
    tens     = 4'd0;
    tens_sub = 7'd0;
    for (int k = 1; k <= 9; k++) begin
      if (rem1 >= 7'(k * 10)) begin
        tens     = 4'(k);
        tens_sub = 7'(k * 10);
      end
    end
  end

  assign ones = 4'(rem1 - tens_sub);
  assign d3   = (hund == 4'd10) ? 4'd1 : 4'd0;
  assign d2   = (hund == 4'd10) ? 4'd0 : hund;

  always_comb begin
    if (mag >= 10'd1000) begin
      ndig    = 3'd4;
      exp_dig = {d3, d2, tens, ones};
    end else if (mag >= 10'd100) begin
      ndig    = 3'd3;
      exp_dig = {d2, tens, ones, 4'd0};
    end else if (mag >= 10'd10) begin
      ndig    = 3'd2;
      exp_dig = {tens, ones, 8'd0};
    end else begin
      ndig    = 3'd1;
      exp_dig = {ones, 12'd0};
    end
  end

  always_comb begin
    sign_en = 1'b1;
    sign_ch = CH_MINUS;
    if (!neg) begin
      if (!special && item.sign_style == SMODE_PLUS) begin
        sign_ch = CH_PLUS;
      end else if (!special && item.sign_style == SMODE_SPACE) begin
        sign_ch = CH_SPACE;
      end else begin
        sign_en = 1'b0;
      end
    end
  end

  assign point = (item.precision != 6'd0) || item.alternate;

  // sign, "0x", leading digit, point, then the fraction digits
  assign body_len  = LEN_W'(sign_en) + LEN_W'(3) + LEN_W'(point)
                   + LEN_W'(item.precision);
  // plus 'p', exponent sign and exponent digits
  assign total_len = body_len + LEN_W'(2) + LEN_W'(ndig);

  assign err = (LEN_W'(item.precision) > LEN_W'(MAX_FIELD))
            || (!special && item.precision != 6'd0 && body_len >= LEN_W'(MAX_FIELD))
            || (!special && total_len > LEN_W'(MAX_FIELD));

  always_comb begin
    desc.err      = err;
    desc.special  = special;
    desc.nan      = frac_nz;
    desc.upper    = item.uppercase;
    desc.sign_en  = sign_en;
    desc.sign_ch  = sign_ch;
    desc.lead_one = (bexp != 11'd0);
    desc.point    = point;
    desc.prec     = item.precision;
    desc.frac     = frac;
    desc.exp_neg  = exp_neg;
    desc.ndig     = ndig;
    desc.exp_dig  = exp_dig;
  end

endmodule

// ===== rtl/dhf_queue.sv =====
// dhf_queue: short descriptor queue between the front and back parts
// depends on dhf_pkg
module dhf_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  dhf_pkg::dhf_desc_t wdata,
  output logic               full,
  input  logic               pop,
  output dhf_pkg::dhf_desc_t rdata,
  output logic               empty
);
  import dhf_pkg::*;

  dhf_desc_t     slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wptr_r, wptr_nxt;
  logic [Q_AW-1:0] rptr_r, rptr_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign full    = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = do_push ? Q_AW'(wptr_r + 1'b1) : wptr_r;
    rptr_nxt = do_pop  ? Q_AW'(rptr_r + 1'b1) : rptr_r;
    cnt_nxt  = cnt_r + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/dhf_back.sv =====
// dhf_back: character sequencer, one character per cycle into the output register while it has room
// depends on dhf_pkg
module dhf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  dhf_pkg::dhf_desc_t q_data,
  output logic               q_pop,
  output logic               out_valid,
  output dhf_pkg::dhf_out_t  out_data,
  input  logic               out_pop
);
  import dhf_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SIGN  = 4'd1;
  localparam logic [3:0] ST_WORD  = 4'd2;
  localparam logic [3:0] ST_ZERO  = 4'd3;
  localparam logic [3:0] ST_X     = 4'd4;
  localparam logic [3:0] ST_LEAD  = 4'd5;
  localparam logic [3:0] ST_POINT = 4'd6;
  localparam logic [3:0] ST_DIGIT = 4'd7;
  localparam logic [3:0] ST_P     = 4'd8;
  localparam logic [3:0] ST_ESIGN = 4'd9;
  localparam logic [3:0] ST_EXP   = 4'd10;
  localparam logic [3:0] ST_ERR   = 4'd11;

  function automatic logic [7:0] up(input logic [7:0] c, input logic upper);
    return upper ? (c & CASE_MASK) : c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_0 + {4'd0, d};
    end else begin
      c = up(CH_LC_A, upper) + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

  function automatic logic [7:0] word_char(input logic nan, input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = nan ? CH_LC_N : CH_LC_I;
      2'd1:    c = nan ? CH_LC_A : CH_LC_N;
      default: c = nan ? CH_LC_N : CH_LC_F;
    endcase
    return c;
  endfunction

  logic [3:0]  state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  dhf_desc_t   desc_r, desc_nxt;
  logic [51:0] frac_r, frac_nxt;
  logic [15:0] expd_r, expd_nxt;
  logic        out_valid_r, out_valid_nxt;
  dhf_out_t    out_r, out_nxt;
  logic        slot_free;
  logic        emit;

  assign slot_free = !out_valid_r || out_pop;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    desc_nxt  = desc_r;
    frac_nxt  = frac_r;
    expd_nxt  = expd_r;
    q_pop     = 1'b0;
    emit      = 1'b0;
    out_nxt   = out_r;
    out_nxt.last  = 1'b0;
    out_nxt.error = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          desc_nxt = q_data;
          frac_nxt = q_data.frac;
          expd_nxt = q_data.exp_dig;
          cnt_nxt  = '0;
          priority if (q_data.err) begin
            state_nxt = ST_ERR;
          end else if (q_data.sign_en) begin
            state_nxt = ST_SIGN;
          end else if (q_data.special) begin
            state_nxt = ST_WORD;
          end else begin
            state_nxt = ST_ZERO;
          end
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          emit              = 1'b1;
          out_nxt.character = desc_r.sign_ch;
          state_nxt         = desc_r.special ? ST_WORD : ST_ZERO;
        end
      end
      ST_WORD: begin
        if (slot_free) begin
          emit              = 1'b1;
          out_nxt.character = up(word_char(desc_r.nan, cnt_r[1:0]), desc_r.upper);
          cnt_nxt           = cnt_r + 6'd1;
          if (cnt_r == 6'd2) begin
            out_nxt.last = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end
      end
      ST_ZERO: begin
        if (slot_free) begin
          emit              = 1'b1;
          out_nxt.character = CH_0;
          state_nxt         = ST_X;
        end
      end
      ST_X: begin
        if (slot_free) begin
          emit              = 1'b1;
          out_nxt.character = up(CH_LC_X, desc_r.upper);
          state_nxt         = ST_LEAD;
        end
      end
      ST_LEAD: begin
        if (slot_free) begin
          emit              = 1'b1;
          out_nxt.character = desc_r.lead_one ? CH_1 : CH_0;
          state_nxt         = desc_r.point ? ST_POINT : ST_P;
        end
      end
      ST_POINT: begin
        if (slot_free) begin
          emit              = 1'b1;
          out_nxt.character = CH_POINT;
          state_nxt         = (desc_r.prec != 6'd0) ? ST_DIGIT : ST_P;
        end
      end
      ST_DIGIT: begin
        // fraction shifts out a nibble at a time; zeros follow the 13th digit
        if (slot_free) begin
          emit              = 1'b1;
          out_nxt.character = hex_char(frac_r[51:48], desc_r.upper);
          frac_nxt          = {frac_r[47:0], 4'd0};
          cnt_nxt           = cnt_r + 6'd1;
          if (cnt_r == desc_r.prec - 6'd1) begin
            state_nxt = ST_P;
          end
        end
      end
      ST_P: begin
        if (slot_free) begin
          emit              = 1'b1;
          out_nxt.character = up(CH_LC_P, desc_r.upper);
          cnt_nxt           = '0;
          state_nxt         = ST_ESIGN;
        end
      end
      ST_ESIGN: begin
        if (slot_free) begin
          emit              = 1'b1;
          out_nxt.character = desc_r.exp_neg ? CH_MINUS : CH_PLUS;
          state_nxt         = ST_EXP;
        end
      end
      ST_EXP: begin
        if (slot_free) begin
          emit              = 1'b1;
          out_nxt.character = CH_0 + {4'd0, expd_r[15:12]};
          expd_nxt          = {expd_r[11:0], 4'd0};
          cnt_nxt           = cnt_r + 6'd1;
          if (cnt_r == {3'd0, desc_r.ndig} - 6'd1) begin
            out_nxt.last = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          emit              = 1'b1;
          out_nxt.character = CH_NUL;
          out_nxt.last      = 1'b1;
          out_nxt.error     = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = emit ? 1'b1 : (out_pop ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    desc_r <= desc_nxt;
    frac_r <= frac_nxt;
    expd_r <= expd_nxt;
    if (emit) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ===== rtl/dhf_checker.sv =====
// dhf_port_checks: port-level checks for double_to_hex_float_text, bound to the top level
// depends on dhf_pkg
module dhf_port_checks (
  input logic              clk,
  input logic              rst_n,
  input logic              push,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input dhf_pkg::dhf_out_t out_item
);
  import dhf_pkg::*;

  // an error item always closes its text
  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.error) |-> out_item.last)
    else $error("error item without last");

  // an error item carries no character
  a_err_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.error) |-> (out_item.character == CH_NUL))
    else $error("error item with nonzero character");

  // a waiting item holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("waiting item changed or vanished");

  // the input side only fills up after a push
  a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
    (!full && !push) |=> !full)
    else $error("full raised without a push");

  // reset leaves nothing queued and room for input
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not clear after reset");

endmodule

bind double_to_hex_float_text dhf_port_checks u_dhf_port_checks (
  .clk      (clk),
  .rst_n    (rst_n),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_item (out_item)
);

// ===== bench/dhf_checker.sv =====
`timescale 1ns / 1ps
// dhf_checker: watches both queues of the hex float text formatter, predicts
// the characters of every accepted item and compares each accepted result
// depends on dhf_pkg for the item types, sizes and ascii codes
module dhf_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic              full,
  input  dhf_pkg::dhf_in_t  in_item,
  input  logic              empty,
  input  logic              pop,
  input  dhf_pkg::dhf_out_t out_item,
  output int unsigned       outstanding,
  output int unsigned       mismatch_count
);
  import dhf_pkg::*;

  localparam logic [10:0] EXP_ALL_ONES  = 11'h7ff;
  localparam int unsigned EXP_BIAS      = 1023;
  localparam int unsigned SUBNORMAL_MAG = 1022;
  localparam int unsigned FRAC_DIGITS   = 13;
  localparam int unsigned PRINT_CAP     = 40;

  dhf_out_t    text_expected [$];
  int unsigned waiting_chars = 0;
  int unsigned mismatches    = 0;
  int unsigned result_seq    = 0;

  assign outstanding    = waiting_chars;
  assign mismatch_count = mismatches;

  function automatic logic [7:0] letter_case(input logic [7:0] lc, input logic up);
    return up ? (lc & CASE_MASK) : lc;
  endfunction

  function automatic void queue_error();
    text_expected.push_back('{character: CH_NUL, last: 1'b1, error: 1'b1});
  endfunction

  // builds the %a text of one item and queues its characters
  function automatic void predict_text(input dhf_in_t it);
    logic [7:0]  txt [$];
    logic [7:0]  dec [$];
    logic [10:0] bexp;
    logic [51:0] frac;
    logic        neg;
    logic        up;
    logic        exp_neg;
    int unsigned mag;
    int unsigned d;
    int unsigned i;
    neg  = it.value_bits[63];
    bexp = it.value_bits[62:52];
    frac = it.value_bits[51:0];
    up   = it.uppercase;
    if (it.precision > MAX_FIELD) begin
      queue_error();
      return;
    end
    if (bexp == EXP_ALL_ONES) begin
      // inf / nan ignore sign mode and alternate
      if (neg) txt.push_back(CH_MINUS);
      if (frac == '0) begin
        txt.push_back(letter_case(CH_LC_I, up));
        txt.push_back(letter_case(CH_LC_N, up));
        txt.push_back(letter_case(CH_LC_F, up));
      end else begin
        txt.push_back(letter_case(CH_LC_N, up));
        txt.push_back(letter_case(CH_LC_A, up));
        txt.push_back(letter_case(CH_LC_N, up));
      end
    end else begin
      if (neg) txt.push_back(CH_MINUS);
      else if (it.sign_style == SMODE_PLUS) txt.push_back(CH_PLUS);
      else if (it.sign_style == SMODE_SPACE) txt.push_back(CH_SPACE);
      txt.push_back(CH_0);
      txt.push_back(letter_case(CH_LC_X, up));
      if (bexp == '0) begin
        txt.push_back(CH_0);
        exp_neg = (frac != '0);
        mag     = (frac != '0) ? SUBNORMAL_MAG : 0;
      end else begin
        txt.push_back(CH_1);
        exp_neg = (bexp < EXP_BIAS);
        mag     = exp_neg ? EXP_BIAS - bexp : bexp - EXP_BIAS;
      end
      if (it.precision != '0 || it.alternate) txt.push_back(CH_POINT);
      for (i = 0; i < it.precision; i++) begin
        d = (i < FRAC_DIGITS) ? frac[51 - 4 * i -: 4] : 0;
        if (d < 10) txt.push_back(CH_0 + 8'(d));
        else txt.push_back(letter_case(CH_LC_A, up) + 8'(d - 10));
        // the field fills up while digits are still going in
        if (txt.size() >= MAX_FIELD) begin
          queue_error();
          return;
        end
      end
      txt.push_back(letter_case(CH_LC_P, up));
      txt.push_back(exp_neg ? CH_MINUS : CH_PLUS);
      do begin
        dec.push_front(CH_0 + 8'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
      foreach (dec[k]) txt.push_back(dec[k]);
    end
    if (txt.size() > MAX_FIELD) begin
      queue_error();
      return;
    end
    foreach (txt[k])
      text_expected.push_back('{character: txt[k], last: (k == txt.size() - 1),
                                error: 1'b0});
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("dhf_checker: %0t ns result %0d: %s",
                                         $time, result_seq, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      text_expected.delete();
    end else begin
      if (push && !full) predict_text(in_item);
      if (pop && !empty) begin
        if (text_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected result char=%02h last=%b error=%b",
                                    out_item.character, out_item.last, out_item.error));
        end else begin
          if (out_item.character !== text_expected[0].character)
            report_mismatch($sformatf("character %02h, expected %02h",
                                      out_item.character, text_expected[0].character));
          if (out_item.last !== text_expected[0].last)
            report_mismatch($sformatf("last %b, expected %b",
                                      out_item.last, text_expected[0].last));
          if (out_item.error !== text_expected[0].error)
            report_mismatch($sformatf("error %b, expected %b",
                                      out_item.error, text_expected[0].error));
          void'(text_expected.pop_front());
        end
        result_seq++;
      end
    end
    waiting_chars <= text_expected.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for the hex float text formatter
// depends on dhf_pkg, double_to_hex_float_text and bench/dhf_checker
module tb_top;
  import dhf_pkg::*;

  // the unused sign mode code, expected to behave like no sign
  localparam logic [1:0]  SMODE_UNUSED  = 2'd3;
  localparam int unsigned RANDOM_ITEMS  = 320;
  localparam int unsigned PHASE_ITEMS   = RANDOM_ITEMS / 4;
  // long receiver hold-off, enough to back the block up into its input
  localparam int unsigned HOLD_CYCLES   = 400;
  // worst case is roughly 345 items of 48 characters under a 95 percent
  // pop stall, plus gaps and the hold-off; this limit is more than ten
  // times that
  localparam int unsigned CYCLE_LIMIT   = 5000000;
  // lets the block drain once its queues are empty
  localparam int unsigned TAIL_CYCLES   = 50;
  localparam logic [10:0] EXP_ALL_ONES  = 11'h7ff;
  localparam int unsigned EXP_BIAS      = 1023;

  typedef enum int unsigned {GAP_NONE, GAP_LIGHT, GAP_HEAVY, GAP_MIXED} gap_style_e;

  logic     clk      = 1'b0;
  logic     rst_n    = 1'b0;
  logic     push     = 1'b0;
  logic     pop      = 1'b0;
  dhf_in_t  in_item  = '0;
  logic     full;
  logic     empty;
  dhf_out_t out_item;

  int unsigned outstanding;
  int unsigned mismatch_count;
  int unsigned cycle_count  = 0;
  logic        hold_request = 1'b0;

  dhf_in_t item_queue [$];

  double_to_hex_float_text DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  dhf_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_item        (in_item),
    .empty          (empty),
    .pop            (pop),
    .out_item       (out_item),
    .outstanding    (outstanding),
    .mismatch_count (mismatch_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // cycle counter: a hung block ends the run here
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic dhf_in_t fmt_item(input logic [63:0] bits, input logic up,
                                       input logic [1:0] smode, input logic alt,
                                       input logic [5:0] prec);
    dhf_in_t it;
    it.value_bits = bits;
    it.uppercase  = up;
    it.sign_style = smode;
    it.alternate  = alt;
    it.precision  = prec;
    return it;
  endfunction

  // random item, weighted toward the classes of double and the precisions
  // around the field limit where the length checks kick in
  function automatic dhf_in_t random_item();
    logic [63:0] bits;
    logic [10:0] bexp;
    logic [51:0] frac;
    logic [5:0]  prec;
    int unsigned pick;
    bits = {$urandom, $urandom};
    frac = bits[51:0];
    pick = $urandom_range(0, 9);
    case (pick)
      0: bexp = '0;                                         // zero
      1: begin                                              // subnormal
        bexp = '0;
        if (frac == '0) frac = 52'd1;
      end
      2: begin                                              // inf or nan
        bexp = EXP_ALL_ONES;
        if ($urandom_range(0, 1) == 0) frac = '0;
      end
      3, 4: bexp = bits[62:52];                             // raw bits
      5: bexp = 11'(EXP_BIAS - 10 + $urandom_range(0, 20)); // exponent near zero
      6: bexp = ($urandom_range(0, 1) == 0) ? 11'd1 : 11'h7fe;
      default: bexp = 11'($urandom_range(1, 2046));
    endcase
    if (pick == 0) frac = '0;
    pick = $urandom_range(0, 9);
    if (pick < 6) prec = 6'($urandom_range(0, 15));
    else if (pick < 8) prec = 6'($urandom_range(0, 63));
    else prec = 6'($urandom_range(36, 49));
    return fmt_item({bits[63], bexp, frac}, 1'($urandom_range(0, 1)),
                    2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), prec);
  endfunction

  // offer one item and hold it until the block takes it; push stays high
  // so a back-to-back item follows without a bubble
  task automatic send_item(input dhf_in_t it);
    in_item <= it;
    push    <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // send everything in item_queue in bursts, with gaps shaped by style
  task automatic drive_items(input gap_style_e style);
    int unsigned burst;
    int unsigned gap;
    while (item_queue.size() != 0) begin
      burst = $urandom_range(1, 16);
      while (burst != 0 && item_queue.size() != 0) begin
        send_item(item_queue.pop_front());
        burst--;
      end
      case (style)
        GAP_NONE:  gap = 0;
        GAP_LIGHT: gap = $urandom_range(0, 3);
        GAP_HEAVY: gap = $urandom_range(5, 40);
        default:   gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      endcase
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    push <= 1'b0;
  endtask

  // sender pause: nothing offered until every expected character is out;
  // it waits on the clock first so the count includes the item accepted just now
  task automatic wait_drained();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // receiver: pop pattern changes per segment, from never stalling to
  // stalling almost always; one long hold-off once the sender asks for it
  initial begin : receiver
    int unsigned stall_pct;
    int unsigned run_len;
    int unsigned hold_cnt;
    logic        hold_served;
    hold_served = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request && !hold_served) begin
        pop <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk);
        hold_served = 1'b1;
      end
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 30;
        2:       stall_pct = 70;
        default: stall_pct = 95;
      endcase
      run_len = $urandom_range(20, 120);
      repeat (run_len) begin
        pop <= ($urandom_range(0, 99) >= stall_pct);
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    gap_style_e phase_style [4];
    phase_style = '{GAP_NONE, GAP_LIGHT, GAP_HEAVY, GAP_MIXED};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed items
    // zero plain, negative zero and space-signed zero with forced point
    item_queue.push_back(fmt_item(64'h0000000000000000, 1'b0, SMODE_NONE, 1'b0, 6'd0));
    item_queue.push_back(fmt_item(64'h8000000000000000, 1'b1, SMODE_PLUS, 1'b1, 6'd0));
    item_queue.push_back(fmt_item(64'h0000000000000000, 1'b0, SMODE_SPACE, 1'b1, 6'd0));
    // one, and a value whose digits run out past the 13th
    item_queue.push_back(fmt_item(64'h3ff0000000000000, 1'b0, SMODE_PLUS, 1'b0, 6'd13));
    item_queue.push_back(fmt_item(64'h3ff123456789abcd, 1'b1, SMODE_SPACE, 1'b0, 6'd16));
    // every hex letter in both cases
    item_queue.push_back(fmt_item(64'h3fefedcba9876543, 1'b0, SMODE_NONE, 1'b0, 6'd13));
    item_queue.push_back(fmt_item(64'hbfefedcba9876543, 1'b1, SMODE_NONE, 1'b0, 6'd13));
    // largest normal, smallest normal, one half
    item_queue.push_back(fmt_item(64'h7fefffffffffffff, 1'b0, SMODE_NONE, 1'b0, 6'd13));
    item_queue.push_back(fmt_item(64'h0010000000000000, 1'b1, SMODE_PLUS, 1'b0, 6'd4));
    item_queue.push_back(fmt_item(64'h3fe0000000000000, 1'b0, SMODE_NONE, 1'b0, 6'd2));
    // smallest and largest subnormal, the latter 47 characters long
    item_queue.push_back(fmt_item(64'h0000000000000001, 1'b0, SMODE_NONE, 1'b1, 6'd13));
    item_queue.push_back(fmt_item(64'h000fffffffffffff, 1'b0, SMODE_NONE, 1'b0, 6'd37));
    // inf and nan: sign mode and alternate have no effect
    item_queue.push_back(fmt_item(64'h7ff0000000000000, 1'b0, SMODE_PLUS, 1'b1, 6'd5));
    item_queue.push_back(fmt_item(64'hfff0000000000000, 1'b1, SMODE_SPACE, 1'b0, 6'd0));
    item_queue.push_back(fmt_item(64'h7ff8000000000000, 1'b0, SMODE_SPACE, 1'b0, 6'd0));
    item_queue.push_back(fmt_item(64'hfff0000000000001, 1'b1, SMODE_NONE, 1'b1, 6'd3));
    // unused sign mode acts as no sign
    item_queue.push_back(fmt_item(64'h3ff8000000000000, 1'b0, SMODE_UNUSED, 1'b0, 6'd1));
    // exactly a full field, then one and two characters too many at the end
    item_queue.push_back(fmt_item(64'h0000000000000000, 1'b0, SMODE_NONE, 1'b0, 6'd41));
    item_queue.push_back(fmt_item(64'h0000000000000000, 1'b0, SMODE_PLUS, 1'b0, 6'd41));
    item_queue.push_back(fmt_item(64'hbff0000000000000, 1'b0, SMODE_NONE, 1'b0, 6'd42));
    // field fills while fraction digits go in
    item_queue.push_back(fmt_item(64'hbff0000000000000, 1'b1, SMODE_NONE, 1'b0, 6'd43));
    item_queue.push_back(fmt_item(64'h4000000000000000, 1'b0, SMODE_NONE, 1'b0, 6'd48));
    // precision over the field, on a finite value and on a nan
    item_queue.push_back(fmt_item(64'h4000000000000000, 1'b0, SMODE_NONE, 1'b0, 6'd49));
    item_queue.push_back(fmt_item(64'hffffffffffffffff, 1'b1, SMODE_UNUSED, 1'b1, 6'd63));
    drive_items(GAP_MIXED);
    wait_drained();

    // the receiver takes its long hold-off during the first random phase,
    // which sends without gaps so the block backs up and raises full
    hold_request <= 1'b1;
    foreach (phase_style[p]) begin
      repeat (PHASE_ITEMS) item_queue.push_back(random_item());
      drive_items(phase_style[p]);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== double_to_hex_float_text.f =====
rtl/dhf_pkg.sv
rtl/dhf_front.sv
rtl/dhf_queue.sv
rtl/dhf_back.sv
rtl/double_to_hex_float_text.sv
rtl/dhf_checker.sv
bench/dhf_checker.sv
bench/tb_top.sv
